FILE: design/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types, codes and widths of the sorted threshold palette.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int OP_W        = 2;
  localparam int VALUE_W     = 32;
  localparam int CHAN_W      = 8;
  localparam int POS_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 9;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  localparam rgb_t BLACK = '{red: '0, green: '0, blue: '0};

  typedef struct packed {
    logic signed [VALUE_W-1:0] threshold;
    rgb_t                      color;
  } entry_t;

  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] value;
    rgb_t                      color;
    logic [POS_W-1:0]          pos;
    logic [COUNT_OUT_W-1:0]    count;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/stp_req_if.sv
// ----------------------------------------------------------------------------
// stp_req_if
// Request channel: operation, value, color and position.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_req_if
  import stp_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;
  logic [CHAN_W-1:0]         color_red;
  logic [CHAN_W-1:0]         color_green;
  logic [CHAN_W-1:0]         color_blue;
  logic [POS_W-1:0]          position;

  modport source (output valid, op, value, color_red, color_green, color_blue, position,
                  input ready);
  modport sink   (input valid, op, value, color_red, color_green, color_blue, position,
                  output ready);
endinterface

`default_nettype wire

FILE: design/stp_rsp_if.sv
// ----------------------------------------------------------------------------
// stp_rsp_if
// Response channel: looked-up color, status and entry count.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_rsp_if
  import stp_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [CHAN_W-1:0]      out_red;
  logic [CHAN_W-1:0]      out_green;
  logic [CHAN_W-1:0]      out_blue;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, out_red, out_green, out_blue, status, entry_count,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, status, entry_count,
                  output ready);
endinterface

`default_nettype wire

FILE: design/stp_cell.sv
// ----------------------------------------------------------------------------
// stp_cell
// One table slot: compares its threshold, shifts up on insert, down on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_cell
  import stp_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic   clk,
  input  wire cmd_t   cmd,
  input  wire entry_t left,
  input  wire logic   left_take,
  input  wire logic   left_above,
  input  wire entry_t right,
  output entry_t      entry,
  output logic        take,
  output logic        above,
  output rgb_t        hit
);

  localparam logic [COUNT_OUT_W-1:0] IDX_C = COUNT_OUT_W'(IDX);
  localparam logic [COUNT_OUT_W-1:0] IDX_P = COUNT_OUT_W'(IDX);

  logic   occupied;
  entry_t fresh;

  assign occupied = IDX_C < cmd.count;
  assign above    = occupied && (entry.threshold > cmd.value);
  assign take     = above || !occupied;
  assign hit      = (above && !left_above) ? entry.color : BLACK;
  assign fresh    = '{threshold: cmd.value, color: cmd.color};

  always_ff @(posedge clk) begin
    if (cmd.ins && take) begin
      entry <= left_take ? left : fresh;
    end else if (cmd.rem && (IDX_P >= {1'b0, cmd.pos})) begin
      entry <= right;
    end
  end

endmodule

`default_nettype wire

FILE: design/sorted_threshold_palette.sv
// ----------------------------------------------------------------------------
// sorted_threshold_palette
// Sorted (threshold, color) table held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel | dir | transfer payload
//  --------+-----+------------------------------------------------------------
//  req     | in  | op, value, color_red, color_green, color_blue, position
//  rsp     | out | out_red, out_green, out_blue, status, entry_count
//
//  All cells compare against the request value in parallel and shift by one
//  slot at the same edge; one request per cycle while no response is stalled.
//  The response is registered at the transfer and is valid in the cycle after.
//  Reset clears the entry count and the response valid; cell contents need none.
//  A stalled response holds and blocks a new request only while it is held.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_threshold_palette
  import stp_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  stp_req_if.sink   req,
  stp_rsp_if.source rsp
);

  localparam int CW = $clog2(ENTRIES + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [COUNT_OUT_W-1:0] count_ext;
  logic [COUNT_OUT_W-1:0] pos_ext;

  logic accept;
  logic full;
  logic bad_pos;
  cmd_t cmd;

  entry_t entries [ENTRIES];
  entry_t right_in [ENTRIES];
  logic   take  [ENTRIES];
  logic   above [ENTRIES];
  rgb_t   hits  [ENTRIES];
  rgb_t   found;

  logic [STATUS_W-1:0] status_next;
  rgb_t                color_next;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;
  assign count_ext = COUNT_OUT_W'(count);
  assign pos_ext   = {1'b0, req.position};
  assign full      = count == CW'(ENTRIES);
  assign bad_pos   = pos_ext >= count_ext;

  always_comb begin
    cmd.ins   = accept && (req.op == OP_INSERT) && !full;
    cmd.rem   = accept && (req.op == OP_REMOVE) && !bad_pos;
    cmd.value = req.value;
    cmd.color = '{red: req.color_red, green: req.color_green, blue: req.color_blue};
    cmd.pos   = req.position;
    cmd.count = count_ext;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_last
      assign right_in[i] = entries[i];
    end else begin : g_mid
      assign right_in[i] = entries[i+1];
    end
    if (i == 0) begin : g_first
      stp_cell #(.IDX(i)) u_cell (
        .clk(clk), .cmd(cmd),
        .left(entries[i]), .left_take(1'b0), .left_above(1'b0),
        .right(right_in[i]),
        .entry(entries[i]), .take(take[i]), .above(above[i]), .hit(hits[i])
      );
    end else begin : g_rest
      stp_cell #(.IDX(i)) u_cell (
        .clk(clk), .cmd(cmd),
        .left(entries[i-1]), .left_take(take[i-1]), .left_above(above[i-1]),
        .right(right_in[i]),
        .entry(entries[i]), .take(take[i]), .above(above[i]), .hit(hits[i])
      );
    end
  end

  always_comb begin
    found = BLACK;
    for (int i = 0; i < ENTRIES; i++) begin
      found = found | hits[i];
    end
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    color_next  = BLACK;
    unique case (req.op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (bad_pos) begin
          status_next = ST_BADPOS;
        end else begin
          count_next = count - CW'(1);
        end
      end
      OP_LOOKUP: color_next = found;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.out_red     <= color_next.red;
      rsp.out_green   <= color_next.green;
      rsp.out_blue    <= color_next.blue;
      rsp.status      <= status_next;
      rsp.entry_count <= COUNT_OUT_W'(count_next);
    end
  end

endmodule

`default_nettype wire

FILE: tb/sorted_threshold_palette_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_threshold_palette_test
// Self-checking bench for the sorted threshold palette. A directed table walks
// the empty, full and bad-position cases and the signed extremes, then random
// insert/remove/lookup traffic sweeps the fill level under random backpressure.
// Each response is checked against its typed row or the local sorted table.
// ----------------------------------------------------------------------------

module sorted_threshold_palette_test;
  import stp_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int IDLE_PCT  = 27;
  localparam int HOLD_CYC  = 80;

  typedef struct packed {
    rgb_t                   color;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count;
  } palette_rsp_t;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    rgb_t                      color;
    logic [POS_W-1:0]          pos;
    bit                        typed;
    palette_rsp_t              want;
  } palette_step_t;

  logic clk = 1'b0;
  logic rst;

  stp_req_if req ();
  stp_rsp_if rsp ();

  sorted_threshold_palette i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // local copy of the sorted table
  logic signed [VALUE_W-1:0] pal_thr [ENTRIES_DEF];
  rgb_t                      pal_col [ENTRIES_DEF];
  int                        pal_used = 0;

  palette_rsp_t              want_q [$];
  palette_step_t             dir_tab [];
  logic signed [VALUE_W-1:0] thr_pool [8];
  int                        mismatches = 0;
  bit                        no_idle = 1'b0;
  bit                        hold_req = 1'b0;
  bit                        fill_up = 1'b1;

  function automatic int first_above(logic signed [VALUE_W-1:0] v);
    for (int i = 0; i < pal_used; i++) begin
      if (pal_thr[i] > v) return i;
    end
    return pal_used;
  endfunction

  function automatic palette_rsp_t palette_apply(palette_step_t s);
    palette_rsp_t r;
    int           at;
    r.color  = BLACK;
    r.status = ST_OK;
    case (s.op)
      OP_INSERT: begin
        if (pal_used >= ENTRIES_DEF) begin
          r.status = ST_FULL;
        end else begin
          at = first_above(s.value);
          for (int i = pal_used; i > at; i--) begin
            pal_thr[i] = pal_thr[i-1];
            pal_col[i] = pal_col[i-1];
          end
          pal_thr[at] = s.value;
          pal_col[at] = s.color;
          pal_used++;
        end
      end
      OP_REMOVE: begin
        if (int'(s.pos) >= pal_used) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = s.pos; i + 1 < pal_used; i++) begin
            pal_thr[i] = pal_thr[i+1];
            pal_col[i] = pal_col[i+1];
          end
          pal_used--;
        end
      end
      OP_LOOKUP: begin
        at = first_above(s.value);
        if (at < pal_used) r.color = pal_col[at];
      end
      default: ;
    endcase
    r.count = COUNT_OUT_W'(pal_used);
    return r;
  endfunction

  function automatic palette_step_t row(logic [OP_W-1:0] op, logic [31:0] value,
                                        logic [23:0] color, logic [7:0] pos, int typed,
                                        logic [23:0] w_color, logic [1:0] w_status,
                                        int w_count);
    palette_step_t s;
    s.op          = op;
    s.value       = value;
    s.color       = color;
    s.pos         = pos;
    s.typed       = (typed != 0);
    s.want.color  = w_color;
    s.want.status = w_status;
    s.want.count  = COUNT_OUT_W'(w_count);
    return s;
  endfunction

  task automatic offer_op(input palette_step_t s);
    palette_rsp_t predicted;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.op          <= s.op;
    req.value       <= s.value;
    req.color_red   <= s.color.red;
    req.color_green <= s.color.green;
    req.color_blue  <= s.color.blue;
    req.position    <= s.pos;
    do @(posedge clk); while (!req.ready);
    predicted = palette_apply(s);
    want_q.push_back(s.typed ? s.want : predicted);
  endtask

  task automatic offer_random(input int n);
    palette_step_t s;
    int            pick;
    int            ins_w;
    for (int k = 0; k < n; k++) begin
      if (pal_used >= ENTRIES_DEF) fill_up = 1'b0;
      else if (pal_used == 0) fill_up = 1'b1;
      ins_w = fill_up ? 60 : 20;
      pick  = $urandom_range(99);
      if (pick < ins_w) s.op = OP_INSERT;
      else if (pick < ins_w + 25) s.op = OP_REMOVE;
      else if (pick < 97) s.op = OP_LOOKUP;
      else s.op = OP_NONE;
      pick = $urandom_range(99);
      if (pick < 40) s.value = thr_pool[$urandom_range(7)];
      else if (pick < 60) s.value = $urandom;
      else if (pick < 80) s.value = $signed($urandom_range(40)) - 20;
      else s.value = thr_pool[$urandom_range(7)] + ($urandom_range(1) ? 1 : -1);
      s.color = 24'($urandom);
      s.pos   = ($urandom_range(99) < 80) ? POS_W'($urandom_range(pal_used))
                                          : POS_W'($urandom_range(255));
      s.typed = 1'b0;
      s.want  = '0;
      offer_op(s);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    palette_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (want_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %0h/%0h/%0h st %0d cnt %0d",
                 $time, rsp.out_red, rsp.out_green, rsp.out_blue, rsp.status,
                 rsp.entry_count);
        mismatches++;
      end else begin
        want = want_q.pop_front();
        check_field("out_red",     int'(want.color.red),   int'(rsp.out_red));
        check_field("out_green",   int'(want.color.green), int'(rsp.out_green));
        check_field("out_blue",    int'(want.color.blue),  int'(rsp.out_blue));
        check_field("status",      int'(want.status),      int'(rsp.status));
        check_field("entry_count", int'(want.count),       int'(rsp.entry_count));
      end
    end
  end

  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYC;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.op          = OP_LOOKUP;
    req.value       = '0;
    req.color_red   = '0;
    req.color_green = '0;
    req.color_blue  = '0;
    req.position    = '0;

    thr_pool[0] = 32'sh8000_0000;
    thr_pool[1] = 32'sh7fff_ffff;
    thr_pool[2] = 0;
    thr_pool[3] = -1;
    for (int i = 4; i < 8; i++) thr_pool[i] = $signed($urandom_range(2000)) - 1000;

    dir_tab = '{
      row(OP_LOOKUP, 32'h0000_0000, 24'h000000, 8'd0,   1, 24'h0, ST_OK,     0),
      row(OP_REMOVE, 32'h0000_0000, 24'h000000, 8'd0,   1, 24'h0, ST_BADPOS, 0),
      row(OP_NONE,   32'hffff_ffff, 24'hffffff, 8'hff,  1, 24'h0, ST_OK,     0),
      row(OP_INSERT, 32'h7fff_ffff, 24'hffffff, 8'd0,   1, 24'h0, ST_OK,     1),
      row(OP_INSERT, 32'h8000_0000, 24'h000000, 8'd0,   1, 24'h0, ST_OK,     2),
      row(OP_INSERT, 32'h0000_0000, 24'h123456, 8'd0,   1, 24'h0, ST_OK,     3),
      row(OP_INSERT, 32'h0000_0000, 24'habcdef, 8'd0,   1, 24'h0, ST_OK,     4),
      row(OP_LOOKUP, 32'h8000_0000, 24'h000000, 8'd0,   0, 24'h0, ST_OK,     0),
      row(OP_LOOKUP, 32'hffff_ffff, 24'h000000, 8'd0,   0, 24'h0, ST_OK,     0),
      row(OP_LOOKUP, 32'h0000_0000, 24'h000000, 8'd0,   0, 24'h0, ST_OK,     0),
      row(OP_LOOKUP, 32'h7fff_ffff, 24'h000000, 8'd0,   1, 24'h0, ST_OK,     4),
      row(OP_REMOVE, 32'h0000_0000, 24'h000000, 8'hff,  1, 24'h0, ST_BADPOS, 4),
      row(OP_INSERT, 32'hffff_fffb, 24'h010203, 8'd0,   1, 24'h0, ST_OK,     5),
      row(OP_INSERT, 32'h0000_0005, 24'h808080, 8'd0,   1, 24'h0, ST_OK,     6),
      row(OP_INSERT, 32'h0000_0000, 24'h5a5a5a, 8'd0,   1, 24'h0, ST_OK,     7),
      row(OP_INSERT, 32'hffff_ffff, 24'ha5a5a5, 8'd0,   1, 24'h0, ST_OK,     8),
      row(OP_INSERT, 32'h0000_0001, 24'hff0000, 8'd0,   1, 24'h0, ST_OK,     9),
      row(OP_INSERT, 32'h7fff_ffff, 24'h00ff00, 8'd0,   1, 24'h0, ST_OK,     10),
      row(OP_INSERT, 32'h8000_0000, 24'h0000ff, 8'd0,   1, 24'h0, ST_OK,     11),
      row(OP_INSERT, 32'h0000_0064, 24'h7f7f7f, 8'd0,   1, 24'h0, ST_OK,     12),
      row(OP_INSERT, 32'hffff_ff9c, 24'hfedcba, 8'd0,   1, 24'h0, ST_OK,     13),
      row(OP_INSERT, 32'h0000_0000, 24'h010101, 8'd0,   1, 24'h0, ST_OK,     14),
      row(OP_INSERT, 32'h0000_0003, 24'hc0ffee, 8'd0,   1, 24'h0, ST_OK,     15),
      row(OP_INSERT, 32'hffff_fffd, 24'h0f0f0f, 8'd0,   1, 24'h0, ST_OK,     16),
      row(OP_INSERT, 32'h0000_002a, 24'h424242, 8'd0,   1, 24'h0, ST_FULL,   16),
      row(OP_REMOVE, 32'h0000_0000, 24'h000000, 8'd16,  1, 24'h0, ST_BADPOS, 16),
      row(OP_LOOKUP, 32'h0000_0000, 24'h000000, 8'd0,   0, 24'h0, ST_OK,     0),
      row(OP_REMOVE, 32'h0000_0000, 24'h000000, 8'd15,  1, 24'h0, ST_OK,     15),
      row(OP_REMOVE, 32'h0000_0000, 24'h000000, 8'd0,   1, 24'h0, ST_OK,     14)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) offer_op(dir_tab[i]);
    offer_random(500);

    req.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);

    hold_req <= 1'b1;
    offer_random(40);

    no_idle <= 1'b1;
    offer_random(300);
    no_idle <= 1'b0;
    offer_random(530);

    req.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/stp_pkg.sv
design/stp_req_if.sv
design/stp_rsp_if.sv
design/stp_cell.sv
design/sorted_threshold_palette.sv
tb/sorted_threshold_palette_test.sv
